// ===== rtl/c2puv_pkg.sv =====
// Shared types, constants and the arctangent table for the polar UV mapper.
package c2puv_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_BITS_DEF   = 12;
    localparam int SIZE_BITS_DEF    = 12;

    localparam int GUARD_BITS = 16;
    localparam int Z_W        = 34;   // signed angle, 2^32 units per turn, with headroom
    localparam int TURN_W     = 33;   // saturated turn in [0, 2^32]
    localparam int DIM_W      = 13;   // src_width / src_height register width
    localparam int SCALE_W    = 24;   // radius_scale register width
    localparam int OUT_W      = 20;
    localparam int SCALE_SHIFT = 16 + GUARD_BITS - 8;
    localparam int VSHIFT      = 24;
    localparam int ATAN_LEN    = 24;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [TURN_W-1:0] FULL_TURN = 33'h1_0000_0000;
    localparam logic [TURN_W-1:0] HALF_TURN = 33'h0_8000_0000;

    localparam logic [DIM_W-1:0]   SRC_WIDTH_RST    = 13'd256;
    localparam logic [DIM_W-1:0]   SRC_HEIGHT_RST   = 13'd256;
    localparam logic [SCALE_W-1:0] RADIUS_SCALE_RST = 24'd65536;

    // atan(2^-i) in turns * 2^32, truncated
    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH    = 2'd0,
        CFG_SRC_HEIGHT   = 2'd1,
        CFG_RADIUS_SCALE = 2'd2
    } c2puv_cfg_idx_t;

    // side info carried alongside each item through the pipeline
    typedef struct packed {
        logic py_zero;
        logic px_neg;
    } c2puv_flags_t;

endpackage

// ===== rtl/c2puv_cell.sv =====
// One CORDIC vectoring iteration with its pipeline register.
module c2puv_cell
    import c2puv_pkg::*;
#(
    parameter int STEP = 0,
    parameter int XY_W = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    input  c2puv_flags_t           flags_in,
    output logic                   valid_out,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out,
    output c2puv_flags_t           flags_out
);

    localparam logic signed [Z_W-1:0] ATAN_Z = signed'(Z_W'(ATAN_TURNS[STEP]));

    logic                   valid_reg;
    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    c2puv_flags_t           flags_reg;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (y_in >= 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_Z;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        flags_reg <= flags_in;
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flags_out = flags_reg;

endmodule

// ===== rtl/c2puv_post.sv =====
// Turn normalization, radius and angle scaling, and edge clamping.
module c2puv_post
    import c2puv_pkg::*;
#(
    parameter int XY_W      = 31,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [Z_W-1:0]  z_in,
    input  c2puv_flags_t           flags_in,
    input  logic [DIM_W-1:0]       src_width,
    input  logic [DIM_W-1:0]       src_height,
    input  logic [SCALE_W-1:0]     radius_scale,
    output logic                   valid_out,
    output logic [OUT_W-1:0]       radial_coord,
    output logic [OUT_W-1:0]       inverse_radial_coord,
    output logic [OUT_W-1:0]       angular_coord
);

    localparam int XP_W  = XY_W - 1;
    localparam int UP_W  = XP_W + SCALE_W;
    localparam int U_W   = UP_W - SCALE_SHIFT;
    localparam int VP_W  = TURN_W + SIZE_BITS;
    localparam int V_W   = VP_W - VSHIFT;
    localparam int LIM_W = SIZE_BITS + 8;
    localparam int CMP_W = (U_W > V_W) ? U_W : V_W;
    localparam int EW    = (DIM_W > SIZE_BITS + 1) ? DIM_W : SIZE_BITS + 1;
    localparam int EXT_W = (LIM_W > OUT_W) ? LIM_W : OUT_W;

    // size register saturated to [2, 2^SIZE_BITS], minus one
    function automatic logic [SIZE_BITS-1:0] size_m1(input logic [DIM_W-1:0] s);
        logic [EW-1:0] se;
        logic [EW-1:0] top;
        logic [EW-1:0] dec;
        se  = EW'(s);
        top = EW'(1) << SIZE_BITS;
        dec = se - EW'(1);
        if (se < EW'(2))
            return SIZE_BITS'(1);
        else if (se > top)
            return {SIZE_BITS{1'b1}};
        else
            return dec[SIZE_BITS-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] edge_clamp(input logic [CMP_W-1:0] c,
                                                    input logic [SIZE_BITS-1:0] sm1);
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] val;
        logic [EXT_W-1:0] ext;
        lim = {sm1, 8'h00};
        if (c >= CMP_W'(lim))
            val = {sm1 - SIZE_BITS'(1), 8'hff};
        else
            val = c[LIM_W-1:0];
        ext = EXT_W'(val);
        return ext[OUT_W-1:0];
    endfunction

    logic [SIZE_BITS-1:0] wm1;
    logic [SIZE_BITS-1:0] hm1;
    logic [LIM_W-1:0]     wlim;

    logic signed [Z_W:0]  tsum;
    logic [TURN_W-1:0]    turn_next;
    logic [XP_W-1:0]      xpos_next;

    logic [3:0]           valid_reg;
    logic [TURN_W-1:0]    turn_reg;
    logic [XP_W-1:0]      xpos_reg;
    logic [UP_W-1:0]      uprod_reg;
    logic [VP_W-1:0]      vprod_reg;
    logic [U_W-1:0]       u_reg;
    logic [V_W-1:0]       v_reg;
    logic [LIM_W-1:0]     inv_reg, inv_next;
    logic [U_W-1:0]       u_next;
    logic [OUT_W-1:0]     radial_reg;
    logic [OUT_W-1:0]     inv_out_reg;
    logic [OUT_W-1:0]     angular_reg;

    assign wm1  = size_m1(src_width);
    assign hm1  = size_m1(src_height);
    assign wlim = {wm1, 8'h00};

    always_comb
    begin
        tsum = (Z_W+1)'(z_in) + signed'((Z_W+1)'(HALF_TURN));
        if (flags_in.py_zero)
            turn_next = flags_in.px_neg ? FULL_TURN : HALF_TURN;
        else if (tsum < 0)
            turn_next = '0;
        else if (tsum > signed'((Z_W+1)'(FULL_TURN)))
            turn_next = FULL_TURN;
        else
            turn_next = tsum[TURN_W-1:0];
        xpos_next = (x_in > 0) ? x_in[XP_W-1:0] : '0;
    end

    always_comb
    begin
        u_next = uprod_reg[UP_W-1:SCALE_SHIFT];
        if (CMP_W'(u_next) <= CMP_W'(wlim))
            inv_next = wlim - u_next[LIM_W-1:0];
        else
            inv_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        turn_reg    <= turn_next;
        xpos_reg    <= xpos_next;
        uprod_reg   <= UP_W'(xpos_reg) * UP_W'(radius_scale);
        vprod_reg   <= VP_W'(turn_reg) * VP_W'(hm1);
        u_reg       <= u_next;
        v_reg       <= vprod_reg[VP_W-1:VSHIFT];
        inv_reg     <= inv_next;
        radial_reg  <= edge_clamp(CMP_W'(u_reg), wm1);
        inv_out_reg <= edge_clamp(CMP_W'(inv_reg), wm1);
        angular_reg <= edge_clamp(CMP_W'(v_reg), hm1);
    end

    assign valid_out            = valid_reg[3];
    assign radial_coord         = radial_reg;
    assign inverse_radial_coord = inv_out_reg;
    assign angular_coord        = angular_reg;

endmodule

// ===== rtl/cartesian_to_polar_uv_map.sv =====
// Top level: input stage, CORDIC cell chain, post stage and config registers.
//
// Takes one pixel offset per clock and returns one result per item, in order.
// The path runs through one input register, one cell per CORDIC iteration
// and the registers of the scaling and clamping stage. busy is never raised,
// so start may be held high continuously. done marks each result for exactly
// one cycle and the results cannot be held off, so the receiver must take
// every one as it appears.
// Registers: 0x0 src_width, 0x4 src_height, 0x8 radius_scale; write them only
// while no item is in flight.
module cartesian_to_polar_uv_map
    import c2puv_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int SIZE_BITS    = SIZE_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    output logic                         done,
    output logic [OUT_W-1:0]             radial_coord,
    output logic [OUT_W-1:0]             inverse_radial_coord,
    output logic [OUT_W-1:0]             angular_coord,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    localparam int XY_W    = COORD_BITS + GUARD_BITS + 3;
    localparam int LATENCY = CORDIC_STEPS + 5;

    logic [DIM_W-1:0]   src_width_reg;
    logic [DIM_W-1:0]   src_height_reg;
    logic [SCALE_W-1:0] radius_scale_reg;
    logic               cfg_wr;
    c2puv_cfg_idx_t     cfg_idx;

    logic                   in_valid_reg;
    logic signed [XY_W-1:0] x0_reg, x0_next;
    logic signed [XY_W-1:0] y0_reg, y0_next;
    logic signed [Z_W-1:0]  z0_reg, z0_next;
    c2puv_flags_t           flags0_reg, flags0_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    logic                   valid_pipe [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] x_pipe     [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] y_pipe     [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  z_pipe     [CORDIC_STEPS+1];
    c2puv_flags_t           flags_pipe [CORDIC_STEPS+1];

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = c2puv_cfg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= SRC_WIDTH_RST;
            src_height_reg   <= SRC_HEIGHT_RST;
            radius_scale_reg <= RADIUS_SCALE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_SRC_WIDTH:    src_width_reg    <= pwdata[DIM_W-1:0];
                CFG_SRC_HEIGHT:   src_height_reg   <= pwdata[DIM_W-1:0];
                CFG_RADIUS_SCALE: radius_scale_reg <= pwdata[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_SRC_WIDTH:    prdata = DATA_W'(src_width_reg);
            CFG_SRC_HEIGHT:   prdata = DATA_W'(src_height_reg);
            CFG_RADIUS_SCALE: prdata = DATA_W'(radius_scale_reg);
            default:          prdata = '0;
        endcase
    end

    // input stage: scale up and fold the left half plane onto the right
    assign busy = 1'b0;

    always_comb
    begin
        xs = XY_W'(pos_x) <<< GUARD_BITS;
        ys = XY_W'(pos_y) <<< GUARD_BITS;
        flags0_next.py_zero = (pos_y == '0);
        flags0_next.px_neg  = pos_x[COORD_BITS-1];
        if (pos_x[COORD_BITS-1])
        begin
            x0_next = -xs;
            y0_next = -ys;
            z0_next = pos_y[COORD_BITS-1] ? -signed'(Z_W'(HALF_TURN))
                                          : signed'(Z_W'(HALF_TURN));
        end
        else
        begin
            x0_next = xs;
            y0_next = ys;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        z0_reg     <= z0_next;
        flags0_reg <= flags0_next;
    end

    assign valid_pipe[0] = in_valid_reg;
    assign x_pipe[0]     = x0_reg;
    assign y_pipe[0]     = y0_reg;
    assign z_pipe[0]     = z0_reg;
    assign flags_pipe[0] = flags0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        c2puv_cell #(
            .STEP (i),
            .XY_W (XY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_pipe[i]),
            .x_in      (x_pipe[i]),
            .y_in      (y_pipe[i]),
            .z_in      (z_pipe[i]),
            .flags_in  (flags_pipe[i]),
            .valid_out (valid_pipe[i+1]),
            .x_out     (x_pipe[i+1]),
            .y_out     (y_pipe[i+1]),
            .z_out     (z_pipe[i+1]),
            .flags_out (flags_pipe[i+1])
        );
    end

    c2puv_post #(
        .XY_W      (XY_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_post (
        .clk                  (clk),
        .rst_n                (rst_n),
        .valid_in             (valid_pipe[CORDIC_STEPS]),
        .x_in                 (x_pipe[CORDIC_STEPS]),
        .z_in                 (z_pipe[CORDIC_STEPS]),
        .flags_in             (flags_pipe[CORDIC_STEPS]),
        .src_width            (src_width_reg),
        .src_height           (src_height_reg),
        .radius_scale         (radius_scale_reg),
        .valid_out            (done),
        .radial_coord         (radial_coord),
        .inverse_radial_coord (inverse_radial_coord),
        .angular_coord        (angular_coord)
    );

    // every accepted item produces a done pulse
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not produce a result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(rst_n, LATENCY)) |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    a_chain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_pipe[CORDIC_STEPS] |-> ##4 done)
        else $error("item lost between cell chain and post stage");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the polar UV mapper: offsets in, texture coordinates checked.
module testbench
    import c2puv_pkg::*;
();

    localparam int              LATENCY        = CORDIC_STEPS_DEF + 5;
    localparam int              WATCHDOG_LIMIT = 2000;
    localparam longint          TURN_HALF      = 64'sh8000_0000;
    localparam longint          TURN_FULL      = 64'sh1_0000_0000;
    localparam logic [1:0]      CFG_UNUSED     = 2'd3;   // no register decoded here
    localparam int              PHASE_ITEMS    = 215;

    typedef struct packed {
        logic [OUT_W-1:0] radial;
        logic [OUT_W-1:0] inv_radial;
        logic [OUT_W-1:0] angular;
    } uv_t;

    logic                        clk;
    logic                        rst_n   = 1'b0;
    logic                        start   = 1'b0;
    logic signed [COORD_BITS_DEF-1:0] pos_x = '0;
    logic signed [COORD_BITS_DEF-1:0] pos_y = '0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [ADDR_W-1:0]           paddr   = '0;
    logic [DATA_W-1:0]           pwdata  = '0;
    logic                        busy;
    logic                        done;
    logic [OUT_W-1:0]            radial_coord;
    logic [OUT_W-1:0]            inverse_radial_coord;
    logic [OUT_W-1:0]            angular_coord;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;

    // register mirror
    logic [DIM_W-1:0]            cfg_width  = SRC_WIDTH_RST;
    logic [DIM_W-1:0]            cfg_height = SRC_HEIGHT_RST;
    logic [SCALE_W-1:0]          cfg_scale  = RADIUS_SCALE_RST;

    uv_t                         uv_expected_q[$];
    int                          errors      = 0;
    int                          idle_pct    = 31;
    int                          stall_count = 0;

    cartesian_to_polar_uv_map i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .pos_x                (pos_x),
        .pos_y                (pos_y),
        .done                 (done),
        .radial_coord         (radial_coord),
        .inverse_radial_coord (inverse_radial_coord),
        .angular_coord        (angular_coord),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned eff_dim(input logic [DIM_W-1:0] s);
        if (s < 2)
            return 2;
        if (s > (1 << SIZE_BITS_DEF))
            return 1 << SIZE_BITS_DEF;
        return s;
    endfunction

    function automatic logic [OUT_W-1:0] edge_clamp(input longint unsigned c,
                                                    input longint unsigned size);
        if (c >= ((size - 1) << 8))
            return OUT_W'(((size - 2) << 8) | 8'hff);
        return OUT_W'(c);
    endfunction

    function automatic uv_t predict_uv(input logic signed [COORD_BITS_DEF-1:0] px,
                                       input logic signed [COORD_BITS_DEF-1:0] py);
        longint            cx, cy, ang, dx, dy, turn;
        longint unsigned   w_eff, h_eff, w_lim, u, inv, v;
        uv_t               r;
        cx  = longint'(px) <<< GUARD_BITS;
        cy  = longint'(py) <<< GUARD_BITS;
        ang = 0;
        // left half plane: rotate by a half turn first
        if (px < 0)
        begin
            ang = (py >= 0) ? TURN_HALF : -TURN_HALF;
            cx  = -cx;
            cy  = -cy;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx  = cx + dx;
                cy  = cy - dy;
                ang = ang + longint'({32'd0, ATAN_TURNS[i]});
            end
            else
            begin
                cx  = cx - dx;
                cy  = cy + dy;
                ang = ang - longint'({32'd0, ATAN_TURNS[i]});
            end
        end
        if (py == 0)
            turn = (px >= 0) ? TURN_HALF : TURN_FULL;
        else
            turn = ang + TURN_HALF;
        if (turn < 0)
            turn = 0;
        if (turn > TURN_FULL)
            turn = TURN_FULL;
        w_eff = eff_dim(cfg_width);
        h_eff = eff_dim(cfg_height);
        w_lim = (w_eff - 1) << 8;
        u     = (cx > 0) ? cx : 0;
        u     = (u * cfg_scale) >> SCALE_SHIFT;
        inv   = (u <= w_lim) ? (w_lim - u) : 0;
        v     = turn;
        v     = (v * (h_eff - 1)) >> VSHIFT;
        r.radial     = edge_clamp(u, w_eff);
        r.inv_radial = edge_clamp(inv, w_eff);
        r.angular    = edge_clamp(v, h_eff);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_val,
                                 input logic [DATA_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        uv_t exp_uv;
        if (rst_n && done)
        begin
            if (uv_expected_q.size() == 0)
            begin
                $display("%0t: result with no item pending: %h %h %h", $time,
                         radial_coord, inverse_radial_coord, angular_coord);
                errors++;
            end
            else
            begin
                exp_uv = uv_expected_q.pop_front();
                compare_field("radial_coord", DATA_W'(exp_uv.radial),
                              DATA_W'(radial_coord));
                compare_field("inverse_radial_coord", DATA_W'(exp_uv.inv_radial),
                              DATA_W'(inverse_radial_coord));
                compare_field("angular_coord", DATA_W'(exp_uv.angular),
                              DATA_W'(angular_coord));
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_offset(input logic signed [COORD_BITS_DEF-1:0] x,
                               input logic signed [COORD_BITS_DEF-1:0] y);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        do
            @(posedge clk);
        while (busy);
        uv_expected_q.push_back(predict_uv(x, y));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (uv_expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            CFG_SRC_WIDTH:    cfg_width  = data[DIM_W-1:0];
            CFG_SRC_HEIGHT:   cfg_height = data[DIM_W-1:0];
            CFG_RADIUS_SCALE: cfg_scale  = data[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [DATA_W-1:0] exp_val);
        logic [DATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        compare_field("prdata", exp_val, rd);
    endtask

    task automatic check_all_regs();
        check_reg(CFG_SRC_WIDTH, DATA_W'(cfg_width));
        check_reg(CFG_SRC_HEIGHT, DATA_W'(cfg_height));
        check_reg(CFG_RADIUS_SCALE, DATA_W'(cfg_scale));
    endtask

    // random upper bits go along to show they are dropped
    task automatic program_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                  input logic [SCALE_W-1:0] s);
        wait_drained();
        write_reg(CFG_SRC_WIDTH, {19'($urandom), w});
        write_reg(CFG_SRC_HEIGHT, {19'($urandom), h});
        write_reg(CFG_RADIUS_SCALE, {8'($urandom), s});
        check_all_regs();
    endtask

    function automatic logic signed [COORD_BITS_DEF-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
            2: return 12'(int'($urandom_range(0, 16)) - 8);
            3: return 12'(int'($urandom_range(0, 200)) - 100);
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 13'd2;
            1: return 13'd4096;
            2: return 13'($urandom);
            default: return 13'($urandom_range(2, 4096));
        endcase
    endfunction

    // mostly a scale of half to one and a half times the one that keeps u inside the texture for the largest radius
    function automatic logic [SCALE_W-1:0] pick_scale(input logic [DIM_W-1:0] w);
        longint unsigned s;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 24'($urandom);
            default:
            begin
                s = ((eff_dim(w) - 1) * 65536 / 4770) * $urandom_range(50, 150) / 100;
                return (s > 24'hFFFFFF) ? 24'hFFFFFF : 24'(s);
            end
        endcase
    endfunction

    task automatic test_reset_values();
        check_all_regs();
    endtask

    task automatic test_directed_offsets();
        send_offset(0, 0);
        send_offset(0, 5);
        send_offset(0, -5);
        send_offset(5, 0);
        send_offset(-5, 0);
        send_offset(-1, 0);
        send_offset(-1, 1);
        send_offset(-1, -1);
        send_offset(1, -1);
        send_offset(12'sh7FF, 12'sh7FF);
        send_offset(12'sh800, 12'sh800);
        send_offset(12'sh800, 12'sh7FF);
        send_offset(12'sh7FF, 12'sh800);
        send_offset(12'sh800, 0);
        send_offset(12'sh7FF, 0);
        send_offset(0, 12'sh7FF);
        send_offset(0, 12'sh800);
        send_offset(100, -37);
        send_offset(-300, 200);
        send_offset(40, 90);
    endtask

    task automatic test_size_extremes();
        program_config(13'd2, 13'd2, 24'd0);
        send_offset(3, 4);
        send_offset(-3, -4);
        send_offset(0, 0);
        program_config(13'd4096, 13'd4096, 24'hFFFFFF);
        send_offset(1, 1);
        send_offset(-1, 12'sh800);
        send_offset(12'sh7FF, -1);
        // register values outside the usable size range
        program_config(13'd0, 13'h1FFF, 24'd3000);
        send_offset(20, -20);
        send_offset(-20, 0);
        program_config(13'd1, 13'd4097, 24'd30000);
        send_offset(7, 9);
        send_offset(-700, 3);
    endtask

    task automatic test_unused_register();
        wait_drained();
        write_reg(CFG_UNUSED, $urandom);
        check_all_regs();
        send_offset(55, -66);
        send_offset(-2, 1);
    endtask

    task automatic test_random_phases();
        logic [DIM_W-1:0] w;
        for (int p = 0; p < 6; p++)
        begin
            w = pick_dim();
            program_config(w, pick_dim(), pick_scale(w));
            idle_pct = (p == 2) ? 0 : 31;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                send_offset(pick_coord(), pick_coord());
            end
        end
        idle_pct = 31;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed_offsets();
        test_size_extremes();
        test_unused_register();
        test_random_phases();

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/c2puv_pkg.sv
rtl/c2puv_cell.sv
rtl/c2puv_post.sv
rtl/cartesian_to_polar_uv_map.sv
sim/testbench.sv
